/* hdl/dtsi_pkg.sv */
// ----------------------------------------------------------------------------
// dtsi_pkg: shared types and constants of the decimal text parser
// Phase, status and controller codes, command/status bundles, character codes.
// ----------------------------------------------------------------------------
package dtsi_pkg;

	localparam int MAX_SCALE = 10000;
	localparam int CHAR_W    = 16;
	localparam int MAG_W     = 64;
	localparam int SCALE_W   = 14;
	localparam int CNT_W     = 16;

	localparam logic [CHAR_W-1:0] CH_POINT  = 16'h002E;
	localparam logic [CHAR_W-1:0] CH_LOW_E  = 16'h0065;
	localparam logic [CHAR_W-1:0] CH_UP_E   = 16'h0045;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 16'h002D;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 16'h002B;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_NINE   = 16'h0039;

	localparam logic [MAG_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [MAG_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		PH_START,
		PH_SIGN,
		PH_MANT,
		PH_EXP,
		PH_EXP_SIGN,
		PH_EXP_DIGITS
	} dtsi_phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_EMPTY,
		ST_NO_DIGITS,
		ST_MAG_OVF,
		ST_SCALE_OVF,
		ST_BAD_EXP,
		ST_EXP_OVF,
		ST_BAD_CHAR
	} dtsi_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCALE
	} dtsi_state_t;

	typedef struct packed {
		logic consume;
		logic check;
		logic step;
		logic load;
	} dtsi_cmd_t;

	typedef struct packed {
		logic scale_done;
	} dtsi_sts_t;

endpackage

/* hdl/dtsi_datapath.sv */
// ----------------------------------------------------------------------------
// dtsi_datapath: parse registers, multiply-by-ten unit and result register
// Consumes characters, runs end-of-text checks, rescales by ten per step.
// ----------------------------------------------------------------------------
module dtsi_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dtsi_pkg::dtsi_cmd_t                cmd,
	input  logic [dtsi_pkg::CHAR_W-1:0]        character,
	input  logic                               char_present,
	output dtsi_pkg::dtsi_sts_t                sts,
	output logic signed [dtsi_pkg::MAG_W-1:0]  unscaled_value,
	output logic [dtsi_pkg::SCALE_W-1:0]       decimal_scale,
	output logic [2:0]                         status
);
	import dtsi_pkg::*;

	dtsi_phase_t        phase_q, phase_n;
	dtsi_status_t       err_q, err_n, final_err;
	logic               neg_q, neg_n;
	logic [MAG_W-1:0]   mag_q, mag_n;
	logic [SCALE_W-1:0] frac_q, frac_n;
	logic               point_q, point_n;
	logic               digit_q, digit_n;
	logic               eneg_q, eneg_n;
	logic [SCALE_W-1:0] exp_q, exp_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;

	logic signed [MAG_W-1:0] value_q;
	logic [SCALE_W-1:0]      scale_q;
	dtsi_status_t            status_q;

	logic [3:0]       dig_val;
	logic             is_dig;
	logic [3:0]       add_val;
	logic [MAG_W+3:0] mag_ext, prod, limit_ext;
	logic             mag_ovf;
	logic [17:0]      exp_ext, exp_next;

	assign is_dig  = (character >= CH_ZERO) && (character <= CH_NINE);
	assign dig_val = character[3:0];

	// shared multiply-by-ten: 10*m + d as shift-add, checked against the signed limit
	assign add_val   = cmd.consume ? dig_val : 4'd0;
	assign mag_ext   = {4'b0, mag_q};
	assign prod      = (mag_ext << 3) + (mag_ext << 1) + {{MAG_W{1'b0}}, add_val};
	assign limit_ext = {4'b0, (neg_q ? NEG_LIMIT : POS_LIMIT)};
	assign mag_ovf   = prod > limit_ext;

	assign exp_ext  = {4'b0, exp_q};
	assign exp_next = (exp_ext << 3) + (exp_ext << 1) + {14'b0, dig_val};

	assign sts.scale_done = (err_q != ST_OK) || !cnt_q[CNT_W-1] || (mag_q == '0);

	always_comb begin
		phase_n = phase_q;
		err_n   = err_q;
		neg_n   = neg_q;
		mag_n   = mag_q;
		frac_n  = frac_q;
		point_n = point_q;
		digit_n = digit_q;
		eneg_n  = eneg_q;
		exp_n   = exp_q;
		cnt_n   = cnt_q;
		if (cmd.consume && char_present && err_q == ST_OK) begin
			unique case (phase_q)
				PH_START, PH_SIGN, PH_MANT: begin
					if (phase_q == PH_START && (character == CH_PLUS || character == CH_MINUS)) begin
						neg_n   = (character == CH_MINUS);
						phase_n = PH_SIGN;
					end else if (is_dig) begin
						digit_n = 1'b1;
						if (mag_ovf) begin
							err_n = ST_MAG_OVF;
						end else begin
							mag_n   = prod[MAG_W-1:0];
							phase_n = PH_MANT;
							if (point_q) begin
								if (frac_q >= SCALE_W'(MAX_SCALE))
									err_n = ST_SCALE_OVF;
								else
									frac_n = frac_q + SCALE_W'(1);
							end
						end
					end else if (character == CH_POINT && !point_q) begin
						point_n = 1'b1;
						phase_n = PH_MANT;
					end else if (!digit_q) begin
						err_n = ST_NO_DIGITS;
					end else if (character == CH_LOW_E || character == CH_UP_E) begin
						phase_n = PH_EXP;
					end else begin
						err_n = ST_BAD_CHAR;
					end
				end
				PH_EXP, PH_EXP_SIGN, PH_EXP_DIGITS: begin
					if (phase_q == PH_EXP && (character == CH_PLUS || character == CH_MINUS)) begin
						eneg_n  = (character == CH_MINUS);
						phase_n = PH_EXP_SIGN;
					end else if (is_dig) begin
						if (exp_next > 18'(MAX_SCALE)) begin
							err_n = ST_EXP_OVF;
						end else begin
							exp_n   = exp_next[SCALE_W-1:0];
							phase_n = PH_EXP_DIGITS;
						end
					end else if (phase_q == PH_EXP_DIGITS) begin
						err_n = ST_BAD_CHAR;
					end else begin
						err_n = ST_BAD_EXP;
					end
				end
				default: err_n = ST_BAD_CHAR;
			endcase
		end else if (cmd.check) begin
			if (err_q == ST_OK) begin
				if (phase_q == PH_START)
					err_n = ST_EMPTY;
				else if (phase_q == PH_SIGN || !digit_q)
					err_n = ST_NO_DIGITS;
				else if (phase_q == PH_EXP || phase_q == PH_EXP_SIGN)
					err_n = ST_BAD_EXP;
			end
			// scale = fraction digits - signed exponent
			if (eneg_q)
				cnt_n = {2'b0, frac_q} + {2'b0, exp_q};
			else
				cnt_n = {2'b0, frac_q} - {2'b0, exp_q};
		end else if (cmd.step) begin
			if (mag_ovf) begin
				err_n = ST_MAG_OVF;
			end else begin
				mag_n = prod[MAG_W-1:0];
				cnt_n = cnt_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		final_err = err_q;
		if (err_q == ST_OK && !cnt_q[CNT_W-1] && cnt_q > CNT_W'(MAX_SCALE))
			final_err = ST_SCALE_OVF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			err_q   <= ST_OK;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			frac_q  <= '0;
			point_q <= 1'b0;
			digit_q <= 1'b0;
			eneg_q  <= 1'b0;
			exp_q   <= '0;
			cnt_q   <= '0;
		end else if (cmd.load) begin
			// result taken into the output register: start a fresh text
			phase_q <= PH_START;
			err_q   <= ST_OK;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			frac_q  <= '0;
			point_q <= 1'b0;
			digit_q <= 1'b0;
			eneg_q  <= 1'b0;
			exp_q   <= '0;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_n;
			err_q   <= err_n;
			neg_q   <= neg_n;
			mag_q   <= mag_n;
			frac_q  <= frac_n;
			point_q <= point_n;
			digit_q <= digit_n;
			eneg_q  <= eneg_n;
			exp_q   <= exp_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= final_err;
			if (final_err != ST_OK) begin
				value_q <= '0;
				scale_q <= '0;
			end else begin
				value_q <= neg_q ? $signed(-mag_q) : $signed(mag_q);
				scale_q <= cnt_q[CNT_W-1] ? '0 : cnt_q[SCALE_W-1:0];
			end
		end
	end

	assign unscaled_value = value_q;
	assign decimal_scale  = scale_q;
	assign status         = status_q;

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> sts.scale_done)
		else $error("result loaded before rescaling finished");

	a_err_latch: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ST_OK && !cmd.load |=> err_q == $past(err_q))
		else $error("latched error changed before end of text");

	a_step_neg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> cnt_q[CNT_W-1] && err_q == ST_OK)
		else $error("rescale step with nonnegative scale or pending error");

endmodule

/* hdl/dtsi_ctrl.sv */
// ----------------------------------------------------------------------------
// dtsi_ctrl: sequencer of the decimal text parser
// Accepts characters, steps end-of-text check and rescale, owns result valid.
// ----------------------------------------------------------------------------
module dtsi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	input  logic                end_of_text,
	output logic                char_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  dtsi_pkg::dtsi_sts_t sts,
	output dtsi_pkg::dtsi_cmd_t cmd
);
	import dtsi_pkg::*;

	dtsi_state_t state_q, state_n;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:  if (char_valid && end_of_text) state_n = S_CHECK;
			S_CHECK: state_n = S_SCALE;
			S_SCALE: if (sts.scale_done && out_free) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		char_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				char_stall  = 1'b0;
				cmd.consume = char_valid;
			end
			S_CHECK: cmd.check = 1'b1;
			S_SCALE: begin
				cmd.step = !sts.scale_done;
				cmd.load = sts.scale_done && out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

	a_end_check: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && end_of_text |=> state_q == S_CHECK)
		else $error("end beat did not start the end-of-text check");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_stall |=> out_valid_q && !$past(cmd.load))
		else $error("stalled result overwritten or dropped");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.consume, cmd.check, cmd.step, cmd.load}))
		else $error("more than one datapath command at once");

endmodule

/* hdl/decimal_text_to_scaled_int.sv */
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_int: decimal text to signed 64-bit scaled integer
// Top level: joins the sequencer and the parse datapath.
// ----------------------------------------------------------------------------
// One character beat is taken per cycle while the sequencer is idle. A
// beat with end_of_text set is consumed like any other and is followed by
// the end-of-text checks and then the rescale loop: a negative scale costs
// one step per power of ten in the shared multiply-by-ten unit, and the
// loop ends at the latest when the magnitude overflows; a load then moves
// the result into the output register. Character beats are stalled from
// the end beat until the result is in the output register, which holds it
// until taken, so the next text can stream in while the result waits.
module decimal_text_to_scaled_int (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               char_valid,
	output logic                               char_stall,
	input  logic [dtsi_pkg::CHAR_W-1:0]        character,
	input  logic                               char_present,
	input  logic                               end_of_text,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [dtsi_pkg::MAG_W-1:0]  unscaled_value,
	output logic [dtsi_pkg::SCALE_W-1:0]       decimal_scale,
	output logic [2:0]                         status
);
	import dtsi_pkg::*;

	dtsi_cmd_t cmd;
	dtsi_sts_t sts;

	dtsi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.end_of_text  (end_of_text),
		.char_stall   (char_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	dtsi_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.character      (character),
		.char_present   (char_present),
		.sts            (sts),
		.unscaled_value (unscaled_value),
		.decimal_scale  (decimal_scale),
		.status         (status)
	);

endmodule
